// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbd assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbd assertion failed");

// Next-cycle implication that also holds across reset
`define DBD_ASSERT_NXT_NR(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("dbd assertion failed");

`endif

// ===== src/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg
// Types and constants shared by the detection box decoder modules.
// ----------------------------------------------------------------------------
package dbd_pkg;

    // Number of class score attributes looked at in a raw row
    localparam int MAX_CLASSES = 1024;

    // Field widths
    localparam int ATTR_W   = 32;
    localparam int POS_W    = 11;
    localparam int CLASS_W  = 11;
    localparam int CONF_W   = 31;
    localparam int PIX_W    = 13;
    localparam int EDGE_W   = 14;
    localparam int CORNER_W = 33;

    // Configuration register widths
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 29;
    localparam int THR_W      = 17;
    localparam int SCALE_W    = 25;
    localparam int PAD_W      = 29;
    localparam int SIZE_W     = 14;

    // Configuration register reset values
    localparam logic [THR_W-1:0]   THR_RESET   = 17'd16384;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 25'd65536;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 14'd640;

    // Stream data widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 96;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DECODE_MODE,
        CFG_SCORE_THRESHOLD,
        CFG_INVERSE_SCALE,
        CFG_PAD_X,
        CFG_PAD_Y,
        CFG_SOURCE_WIDTH,
        CFG_SOURCE_HEIGHT
    } cfg_reg_t;

    // Per-result side information carried down the pipeline
    typedef struct packed {
        logic                      found;
        logic                      last;
        logic [CONF_W-1:0]         score;
        logic signed [CLASS_W-1:0] cls;
    } res_info_t;

    // Row decision handed from the accumulator to the unmap stages
    typedef struct packed {
        res_info_t                  info;
        logic signed [CORNER_W-1:0] x1;
        logic signed [CORNER_W-1:0] y1;
        logic signed [CORNER_W-1:0] x2;
        logic signed [CORNER_W-1:0] y2;
    } job_t;

    // Result tdata layout, left in the lowest bits
    typedef struct packed {
        logic signed [CLASS_W-1:0] class_index;
        logic [CONF_W-1:0]         confidence;
        logic [EDGE_W-1:0]         bottom;
        logic [EDGE_W-1:0]         right;
        logic [PIX_W-1:0]          top;
        logic [PIX_W-1:0]          left;
    } out_data_t;

endpackage

// ===== src/dbd_accum.sv =====
// ----------------------------------------------------------------------------
// dbd_accum
// Per-row attribute tracking: position count, first four values, best score
// and class. Judges each row at its last attribute and registers the job.
// ----------------------------------------------------------------------------
module dbd_accum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic                              advance,
    input  logic signed [dbd_pkg::ATTR_W-1:0] attr_value,
    input  logic                              row_end,
    input  logic                              frame_end,
    input  logic                              decode_mode,
    input  logic [dbd_pkg::THR_W-1:0]         score_threshold,
    output dbd_pkg::job_t                     job,
    output logic                              job_valid
);
    import dbd_pkg::*;

    localparam logic [POS_W:0]   SCORE_END = (POS_W+1)'(MAX_CLASSES + 4);
    localparam logic [POS_W-1:0] POS_MAX   = '1;

    // Round half away from zero to whole classes, saturate to -1..1023
    function automatic logic signed [CLASS_W-1:0] round_class(
        input logic signed [ATTR_W-1:0] v
    );
        logic [ATTR_W:0]           sum;
        logic [ATTR_W-16:0]        whole;
        logic signed [CLASS_W-1:0] r;
        sum   = {1'b0, v} + (ATTR_W+1)'(32768);
        whole = sum[ATTR_W:16];
        if (v[ATTR_W-1]) begin
            r = (v <= -32'sd32768) ? -11'sd1 : 11'sd0;
        end else if (whole > (ATTR_W-15)'(1023)) begin
            r = 11'sd1023;
        end else begin
            r = $signed(whole[CLASS_W-1:0]);
        end
        return r;
    endfunction

    logic [POS_W-1:0]          pos_reg, pos_next;
    logic signed [ATTR_W-1:0]  box_reg [4];
    logic signed [ATTR_W-1:0]  top_score_reg, top_score_next;
    logic signed [CLASS_W-1:0] best_class_reg, best_class_next;
    logic signed [ATTR_W-1:0]  upd_score;
    logic signed [CLASS_W-1:0] upd_class;
    logic signed [ATTR_W-1:0]  thr_s;
    logic signed [ATTR_W-2:0]  half_w, half_h;
    logic                      row_done, keep;
    job_t                      job_reg, job_next;
    logic                      job_valid_reg, job_valid_next;

    // Best score/class update for this attribute
    always_comb begin
        upd_score = top_score_reg;
        upd_class = best_class_reg;
        if (!decode_mode) begin
            if (pos_reg >= POS_W'(4) && {1'b0, pos_reg} < SCORE_END &&
                attr_value > top_score_reg) begin
                upd_score = attr_value;
                upd_class = $signed(pos_reg - POS_W'(4));
            end
        end else begin
            if (pos_reg == POS_W'(4)) begin
                upd_score = attr_value;
            end else if (pos_reg == POS_W'(5)) begin
                upd_class = round_class(attr_value);
            end
        end
    end

    // Row decision and corner forming
    always_comb begin
        row_done = row_end | frame_end;
        thr_s    = $signed({{(ATTR_W-THR_W){1'b0}}, score_threshold});
        half_w   = box_reg[2][ATTR_W-1:1];
        half_h   = box_reg[3][ATTR_W-1:1];
        job_next = job_reg;
        if (!decode_mode) begin
            keep        = (pos_reg >= POS_W'(4)) && (upd_score >= thr_s);
            job_next.x1 = CORNER_W'(box_reg[0]) - CORNER_W'(half_w);
            job_next.x2 = CORNER_W'(box_reg[0]) + CORNER_W'(half_w);
            job_next.y1 = CORNER_W'(box_reg[1]) - CORNER_W'(half_h);
            job_next.y2 = CORNER_W'(box_reg[1]) + CORNER_W'(half_h);
        end else begin
            keep        = (pos_reg >= POS_W'(5)) && (upd_score > thr_s);
            job_next.x1 = CORNER_W'(box_reg[0]);
            job_next.y1 = CORNER_W'(box_reg[1]);
            job_next.x2 = CORNER_W'(box_reg[2]);
            job_next.y2 = CORNER_W'(box_reg[3]);
        end
        job_next.info.found = keep;
        job_next.info.last  = frame_end;
        job_next.info.score = upd_score[CONF_W-1:0];
        job_next.info.cls   = upd_class;
    end

    // Row state next values
    always_comb begin
        pos_next        = pos_reg;
        top_score_next  = top_score_reg;
        best_class_next = best_class_reg;
        if (accept) begin
            if (row_done) begin
                pos_next        = '0;
                top_score_next  = '0;
                best_class_next = -11'sd1;
            end else begin
                pos_next        = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
                top_score_next  = upd_score;
                best_class_next = upd_class;
            end
        end
        job_valid_next = job_valid_reg;
        if (advance) begin
            job_valid_next = accept && row_done && (keep || frame_end);
        end
    end

    // Row state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            top_score_reg  <= '0;
            best_class_reg <= -11'sd1;
            job_valid_reg  <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            top_score_reg  <= top_score_next;
            best_class_reg <= best_class_next;
            job_valid_reg  <= job_valid_next;
        end
    end

    // Captured box values and job payload
    always_ff @(posedge aclk) begin
        if (accept && pos_reg < POS_W'(4)) begin
            box_reg[pos_reg[1:0]] <= attr_value;
        end
        if (advance && accept && row_done) begin
            job_reg <= job_next;
        end
    end

    assign job       = job_reg;
    assign job_valid = job_valid_reg;

endmodule

// ===== src/dbd_unmap.sv =====
// ----------------------------------------------------------------------------
// dbd_unmap
// Two-stage corner unmap: (v - pad) * inverse_scale, then clamp to the
// source size and round half up to whole pixels.
// ----------------------------------------------------------------------------
module dbd_unmap (
    input  logic                                aclk,
    input  logic                                prod_en,
    input  logic                                pix_en,
    input  logic signed [dbd_pkg::CORNER_W-1:0] corner,
    input  logic [dbd_pkg::PAD_W-1:0]           pad,
    input  logic [dbd_pkg::SIZE_W-1:0]          size,
    input  logic [dbd_pkg::SCALE_W-1:0]         inverse_scale,
    output logic [dbd_pkg::PIX_W-1:0]           pixel
);
    import dbd_pkg::*;

    localparam int DIFF_W = CORNER_W + 1;
    localparam int PROD_W = DIFF_W + SCALE_W + 1;
    localparam int INT_W  = PROD_W - 33;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [SCALE_W:0]   scale_s;
    logic signed [PROD_W-1:0]  prod_next, prod_reg;
    logic [PIX_W-1:0]          hi;
    logic [PIX_W-1:0]          pix_next, pix_reg;

    // Offset and scale
    always_comb begin
        diff      = $signed({corner[CORNER_W-1], corner}) -
                    $signed({{(DIFF_W-PAD_W){1'b0}}, pad});
        scale_s   = $signed({1'b0, inverse_scale});
        prod_next = PROD_W'(diff) * PROD_W'(scale_s);
    end

    // Clamp to 0..size-1, at most 8191, and round half up
    always_comb begin
        if (size == '0) begin
            hi = '0;
        end else if (size > SIZE_W'(8192)) begin
            hi = '1;
        end else begin
            hi = PIX_W'(size - SIZE_W'(1));
        end
        if (prod_reg[PROD_W-1]) begin
            pix_next = '0;
        end else if (prod_reg[PROD_W-2:32] >= INT_W'(hi)) begin
            pix_next = hi;
        end else begin
            pix_next = prod_reg[32+PIX_W-1:32] + PIX_W'(prod_reg[31]);
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en) begin
            prod_reg <= prod_next;
        end
        if (pix_en) begin
            pix_reg <= pix_next;
        end
    end

    assign pixel = pix_reg;

endmodule

// ===== src/detection_box_decoder.sv =====
// Path: a row judged at its last attribute passes the job, product, pixel
// and output registers to m_tvalid; rows giving no result produce nothing.
// Throughput: one attribute per cycle while m_tready does not stall the
// four-stage pipeline (row judge, multiply, clamp/round, edge fix-up).
// Reset: synchronous on aresetn low; configuration returns to its defaults,
// row state and all pipeline valid flags clear.
// ----------------------------------------------------------------------------
// detection_box_decoder
// Streams detector attributes row by row, takes the best or decoded class, and emits
// letterbox-unmapped, clamped boxes plus an end-of-frame marker.
// ----------------------------------------------------------------------------
module detection_box_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [dbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dbd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Attribute input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dbd_pkg::IN_TDATA_W-1:0]     s_tdata,   // attr_value
    input  logic                               s_tlast,   // row_end
    input  logic                               s_tuser,   // frame_end
    // Detection output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // left, top, right, bottom, confidence, class_index
    output logic [dbd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,   // last_of_frame
    output logic                               m_tuser    // found
);
    import dbd_pkg::*;

    logic                mode_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [PAD_W-1:0]    pad_x_reg, pad_y_reg;
    logic [SIZE_W-1:0]   width_reg, height_reg;

    logic                adv_a, adv_b, adv_c, adv_d;
    logic                accept;
    job_t                job;
    logic                job_valid;
    logic                vb_reg, vc_reg, vd_reg;
    res_info_t           info_b_reg, info_c_reg;
    logic [PIX_W-1:0]    pix_l, pix_t, pix_r, pix_b;
    logic [EDGE_W-1:0]   right_min, bottom_min;
    out_data_t           out_next, out_reg;
    logic                last_reg, found_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 1'b0;
            thr_reg    <= THR_RESET;
            scale_reg  <= SCALE_RESET;
            pad_x_reg  <= '0;
            pad_y_reg  <= '0;
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                CFG_DECODE_MODE:     mode_reg   <= cfg_wdata[0];
                CFG_SCORE_THRESHOLD: thr_reg    <= cfg_wdata[THR_W-1:0];
                CFG_INVERSE_SCALE:   scale_reg  <= cfg_wdata[SCALE_W-1:0];
                CFG_PAD_X:           pad_x_reg  <= cfg_wdata[PAD_W-1:0];
                CFG_PAD_Y:           pad_y_reg  <= cfg_wdata[PAD_W-1:0];
                CFG_SOURCE_WIDTH:    width_reg  <= cfg_wdata[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT:   height_reg <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance chain: a stage moves when empty or when the next moves
    assign adv_d    = !vd_reg || m_tready;
    assign adv_c    = !vc_reg || adv_d;
    assign adv_b    = !vb_reg || adv_c;
    assign adv_a    = !job_valid || adv_b;
    assign s_tready = adv_a;
    assign accept   = s_tvalid && s_tready;

    // Row tracking and judgement
    dbd_accum u_accum (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .advance         (adv_a),
        .attr_value      ($signed(s_tdata[ATTR_W-1:0])),
        .row_end         (s_tlast),
        .frame_end       (s_tuser),
        .decode_mode     (mode_reg),
        .score_threshold (thr_reg),
        .job             (job),
        .job_valid       (job_valid)
    );

    // Corner unmap units
    dbd_unmap u_unmap_l (
        .aclk (aclk), .prod_en (adv_b), .pix_en (adv_c), .corner (job.x1),
        .pad (pad_x_reg), .size (width_reg), .inverse_scale (scale_reg), .pixel (pix_l)
    );
    dbd_unmap u_unmap_t (
        .aclk (aclk), .prod_en (adv_b), .pix_en (adv_c), .corner (job.y1),
        .pad (pad_y_reg), .size (height_reg), .inverse_scale (scale_reg), .pixel (pix_t)
    );
    dbd_unmap u_unmap_r (
        .aclk (aclk), .prod_en (adv_b), .pix_en (adv_c), .corner (job.x2),
        .pad (pad_x_reg), .size (width_reg), .inverse_scale (scale_reg), .pixel (pix_r)
    );
    dbd_unmap u_unmap_b (
        .aclk (aclk), .prod_en (adv_b), .pix_en (adv_c), .corner (job.y2),
        .pad (pad_y_reg), .size (height_reg), .inverse_scale (scale_reg), .pixel (pix_b)
    );

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (adv_b) vb_reg <= job_valid;
            if (adv_c) vc_reg <= vb_reg;
            if (adv_d) vd_reg <= vc_reg;
        end
    end

    // Edge fix-up; markers carry all-zero data
    always_comb begin
        right_min  = EDGE_W'(pix_l) + EDGE_W'(1);
        bottom_min = EDGE_W'(pix_t) + EDGE_W'(1);
        out_next   = '0;
        if (info_c_reg.found) begin
            out_next.left        = pix_l;
            out_next.top         = pix_t;
            out_next.right       = (EDGE_W'(pix_r) < right_min) ? right_min : EDGE_W'(pix_r);
            out_next.bottom      = (EDGE_W'(pix_b) < bottom_min) ? bottom_min : EDGE_W'(pix_b);
            out_next.confidence  = info_c_reg.score;
            out_next.class_index = info_c_reg.cls;
        end
    end

    // Side information and output register
    always_ff @(posedge aclk) begin
        if (adv_b) info_b_reg <= job.info;
        if (adv_c) info_c_reg <= info_b_reg;
        if (adv_d) begin
            out_reg   <= out_next;
            last_reg  <= info_c_reg.last;
            found_reg <= info_c_reg.found;
        end
    end

    assign m_tvalid = vd_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = found_reg;

endmodule

// ===== src/dbd_checker.sv =====
// ----------------------------------------------------------------------------
// dbd_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dbd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dbd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast,
    input logic                            m_tuser
);
    import dbd_pkg::*;

    out_data_t d;
    assign d = m_tdata;

    // A stalled result transaction holds its data
    `DBD_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Nothing is offered right after reset
    `DBD_ASSERT_NXT_NR(a_reset_idle, aclk, !aresetn, !m_tvalid)

    // A bare marker only closes a frame and carries no box
    `DBD_ASSERT_IMP(a_marker, aclk, aresetn, m_tvalid && !m_tuser, m_tlast && (m_tdata == '0))

    // Boxes always have positive extent
    `DBD_ASSERT_IMP(a_extent, aclk, aresetn, m_tvalid && m_tuser, (d.right > {1'b0, d.left}) && (d.bottom > {1'b0, d.top}))

endmodule

bind detection_box_decoder dbd_checker u_dbd_checker (.*);
